### hw/rtl/pdtb_pkg.sv
// Shared types, widths and constants of the per-device token bucket.
`default_nettype none

package pdtb_pkg;

    localparam int unsigned DEVICES_DEF = 256;
    localparam int unsigned IDX_W       = 8;
    localparam int unsigned TIME_W      = 64;
    localparam int unsigned TOK_W       = 26;
    localparam int unsigned CFG_W       = 16;
    localparam int unsigned PROD_W      = TOK_W + CFG_W;
    localparam int unsigned ENTRY_W     = TOK_W + TIME_W;
    localparam int unsigned MILLI       = 1000;

    localparam logic [CFG_W-1:0] BURST_RST = 16'd16;
    localparam logic [CFG_W-1:0] RATE_RST  = 16'd10;

    // register index, taken from paddr[2]
    localparam logic REG_BURST = 1'b0;
    localparam logic REG_RATE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DELTA,
        ST_FILL
    } t_state;

    function automatic int unsigned addr_w(input int unsigned depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pdtb_ram.sv
// Generic single-port synchronous RAM with registered read.
`default_nettype none

module pdtb_ram
    import pdtb_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [addr_w(DEPTH)-1:0]  i_addr,
    input  wire logic [WIDTH-1:0]          i_wdata,
    output logic      [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

### hw/rtl/per_device_token_bucket.sv
// Top level of the per-device token bucket rate limiter.
// An accepted item passes the read, delta and fill states; its result strobes
// on o_valid, registered from the fill state. A new item waits until the last
// is through the read, delta, multiply and write-back steps on the single bucket
// memory port; start is taken again in the cycle that carries the result, and
// the receiver cannot stall. Reset (synchronous, i_rst_n low): the config
// registers return to defaults and a clearing pass zeroes the memory, busy high.
`default_nettype none

module per_device_token_bucket
    import pdtb_pkg::*;
#(
    parameter int unsigned DEVICES = DEVICES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command side
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [IDX_W-1:0]  i_device_index,
    input  wire logic [TIME_W-1:0] i_time_ms,
    // result side
    output logic                   o_valid,
    output logic                   o_allowed,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam int unsigned SLOT_W = addr_w(DEVICES);
    localparam int unsigned IDX_N  = 1 << IDX_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_burst;
    logic [CFG_W-1:0] r_rate;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst <= BURST_RST;
            r_rate  <= RATE_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_BURST: r_burst <= pwdata[CFG_W-1:0];
                REG_RATE:  r_rate  <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BURST: prdata = {(32 - CFG_W)'(0), r_burst};
            REG_RATE:  prdata = {(32 - CFG_W)'(0), r_rate};
        endcase
    end

    // Bucket cap in millitokens; burst * 1000 always fits in TOK_W bits.
    logic [TOK_W-1:0] w_cap;
    assign w_cap = TOK_W'(TOK_W'(r_burst) * TOK_W'(MILLI));

    // ------------------------------------------------------------------
    // Device index to slot: a constant table of index modulo DEVICES,
    // worked out at elaboration.
    // ------------------------------------------------------------------
    logic [SLOT_W-1:0] w_slot_tab [IDX_N];
    logic [SLOT_W-1:0] w_slot;

    for (genvar gi = 0; gi < IDX_N; gi++) begin : g_slot
        localparam int unsigned SLOT_OF = gi % DEVICES;
        assign w_slot_tab[gi] = SLOT_W'(SLOT_OF);
    end

    assign w_slot = w_slot_tab[i_device_index];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_state            r_state;
    t_state            n_state;
    logic [SLOT_W-1:0] r_clr_cnt;
    logic [SLOT_W-1:0] n_clr_cnt;
    logic              w_accept;
    logic              w_clr_last;

    assign w_accept   = start && !busy;
    assign w_clr_last = (r_clr_cnt == SLOT_W'(DEVICES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
        end
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (w_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:  n_state = ST_DELTA;
            ST_DELTA: n_state = ST_FILL;
            ST_FILL:  n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // Bucket memory: {millitokens, last seen time} per slot. One item is
    // in flight at a time, so the write-back always lands before the next
    // read and no forwarding is needed.
    // ------------------------------------------------------------------
    logic                 w_ram_we;
    logic [SLOT_W-1:0]    w_ram_addr;
    logic [ENTRY_W-1:0]   w_ram_wdata;
    logic [ENTRY_W-1:0]   w_ram_rdata;

    logic [SLOT_W-1:0]    r_slot;
    logic [TIME_W-1:0]    r_now;
    logic [TOK_W-1:0]     r_tok;
    logic [TIME_W-1:0]    r_dt;
    logic                 r_sat;
    logic [PROD_W-1:0]    r_prod;
    logic [TOK_W-1:0]     w_tok_new;

    // outputs of the sequencer
    always_comb begin
        busy        = 1'b1;
        w_ram_we    = 1'b0;
        w_ram_addr  = w_slot;
        w_ram_wdata = {w_tok_new, r_now};
        unique case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_clr_cnt;
                w_ram_wdata = '0;
            end
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_FILL: begin
                w_ram_we   = 1'b1;
                w_ram_addr = r_slot;
            end
            default: begin
                w_ram_addr = r_slot;
            end
        endcase
    end

    pdtb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEVICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic [TOK_W-1:0]  w_rd_tok;
    logic [TIME_W-1:0] w_rd_last;
    logic              w_fresh;

    assign w_rd_tok  = w_ram_rdata[ENTRY_W-1:TIME_W];
    assign w_rd_last = w_ram_rdata[TIME_W-1:0];
    // a stored time of zero marks a fresh slot: fill to the cap, no elapsed time
    assign w_fresh   = (w_rd_last == '0);

    // final step: add the refill, clamp to the cap, spend one token if there
    logic [PROD_W:0]   w_sum;
    logic [TOK_W-1:0]  w_tok_clamp;
    logic              w_allow;

    assign w_sum       = (PROD_W + 1)'(r_tok)
                       + (PROD_W + 1)'(r_sat ? PROD_W'(w_cap) : r_prod);
    assign w_tok_clamp = (w_sum > (PROD_W + 1)'(w_cap)) ? w_cap : w_sum[TOK_W-1:0];
    assign w_allow     = (w_tok_clamp >= TOK_W'(MILLI));
    assign w_tok_new   = w_allow ? (w_tok_clamp - TOK_W'(MILLI)) : w_tok_clamp;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_slot <= w_slot;
            r_now  <= i_time_ms;
        end
        if (r_state == ST_READ) begin
            r_tok <= w_fresh ? w_cap : w_rd_tok;
            // time running backward adds nothing
            if (w_fresh || (r_now < w_rd_last)) begin
                r_dt <= '0;
            end else begin
                r_dt <= r_now - w_rd_last;
            end
        end
        if (r_state == ST_DELTA) begin
            // saturate long gaps at the cap; below it the product stays narrow
            r_sat  <= (r_dt >= TIME_W'(w_cap));
            r_prod <= PROD_W'(r_dt[TOK_W-1:0]) * PROD_W'(r_rate);
        end
        if (r_state == ST_FILL) begin
            o_allowed <= w_allow;
        end
    end

    // result strobe, one cycle per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == ST_FILL);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pdtb_checker.sv
// Port-level checker of the per-device token bucket, bound to the top level.
`default_nettype none

module pdtb_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);

    // a reset always starts a clearing pass
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low after reset");

    // an accepted item holds off the next one
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after accept");

    // every accepted item yields its result on o_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("result missing after accept");

    // a result strobes for a single cycle
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // the result cycle is already open for the next item
    a_ready_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy during result cycle");

endmodule

bind per_device_token_bucket pdtb_checker u_pdtb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

`default_nettype wire
